/* sv/ln1p_pkg.sv */
// ----------------------------------------------------------------------------
// ln1p_pkg
// Shared widths, reset value and sequencer states of the ln(1+x) evaluator.
// ----------------------------------------------------------------------------
package ln1p_pkg;

  localparam int POINT_W       = 31;
  localparam int EPS_W         = 27;
  localparam int LOG_W         = 35;
  localparam int TERMS_W       = 13;
  localparam int FRAC_BITS     = 30;
  localparam int MAG_W         = POINT_W;
  localparam int MAX_TERMS_DEF = 4096;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1074);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ITER,
    ST_UPD,
    ST_DONE
  } state_e;

endpackage

/* sv/ln1p_if.sv */
// ----------------------------------------------------------------------------
// ln1p_if
// Valid/ready channels: input point word and result word.
// ----------------------------------------------------------------------------
interface ln1p_in_if
  import ln1p_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point;

  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface

interface ln1p_out_if
  import ln1p_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [LOG_W-1:0] log_value;
  logic [TERMS_W-1:0]      terms_used;
  logic                    hit_limit;

  modport source (output valid, output log_value, output terms_used, output hit_limit,
                  input ready);
  modport sink   (input valid, input log_value, input terms_used, input hit_limit,
                  output ready);
endinterface

/* sv/ln1p_series_evaluator_top.sv */
// ----------------------------------------------------------------------------
// ln1p_series_evaluator_top
// Series evaluator of ln(1+x) with bit-serial multiply and divide.
// ----------------------------------------------------------------------------
// One word in, one word out. Each series term passes a check state, then an
// iterate state in which a shift-add multiplier (term * x) and a restoring
// divider (term / n) work through all MAG_W bits, then an update state.
// The term count is set by the eps register and capped at MAX_TERMS. A new
// point is taken once the previous result sits in the output register.
module ln1p_series_evaluator_top
  import ln1p_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [EPS_W-1:0] cfg_data_i,
  ln1p_in_if.sink          in_i,
  ln1p_out_if.source       out_o
);

  localparam int NW  = $clog2(MAX_TERMS + 1);
  localparam int BCW = $clog2(MAG_W);
  localparam int PW  = 2 * MAG_W + 1;

  state_e state_q, state_d;

  logic [EPS_W-1:0]       eps_q;
  logic [MAG_W-1:0]       xmag_q, tmag_q, div_q, mlo_q;
  logic [MAG_W:0]         mhi_q;
  logic [NW-1:0]          rem_q, n_q;
  logic                   xneg_q, tneg_q, hit_q;
  logic [BCW-1:0]         bit_q;
  logic signed [LOG_W-1:0] sum_q;

  logic                   out_valid_q;
  logic signed [LOG_W-1:0] out_log_q;
  logic [TERMS_W-1:0]     out_terms_q;
  logic                   out_hit_q;

  logic                   in_acc, out_acc;
  logic [MAG_W-1:0]       pt_mag;
  logic [NW:0]            trial, trial_sub;
  logic                   qbit;
  logic [MAG_W:0]         madd;
  logic [PW-1:0]          prod;
  logic signed [LOG_W:0]  sum_ext, sum_new;
  logic [31:0]            n_ext;
  logic                   last_bit;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign pt_mag  = in_i.point[POINT_W-1] ? MAG_W'(~in_i.point + 1'b1) : MAG_W'(in_i.point);

  // restoring divide: one quotient bit per cycle
  assign trial     = {rem_q, div_q[MAG_W-1]};
  assign trial_sub = trial - {1'b0, n_q};
  assign qbit      = (trial >= {1'b0, n_q});

  // shift-add multiply: one multiplier bit per cycle
  assign madd = mhi_q + (mlo_q[0] ? {1'b0, tmag_q} : '0);
  assign prod = {mhi_q, mlo_q};

  assign sum_ext = LOG_W'(sum_q) + (tneg_q ? -($signed({(LOG_W-MAG_W+1)'(0), div_q}))
                                           :   $signed({(LOG_W-MAG_W+1)'(0), div_q}));
  always_comb begin
    sum_new = sum_ext;
    if (sum_ext > $signed({2'b00, {(LOG_W-1){1'b1}}})) begin
      sum_new = {2'b00, {(LOG_W-1){1'b1}}};
    end else if (sum_ext < $signed({2'b11, {(LOG_W-1){1'b0}}})) begin
      sum_new = {2'b11, {(LOG_W-1){1'b0}}};
    end
  end

  assign n_ext    = 32'(n_q);
  assign last_bit = (bit_q == BCW'(MAG_W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_CHECK;
      ST_CHECK: begin
        if (tmag_q < MAG_W'(eps_q) || n_q >= NW'(MAX_TERMS)) state_d = ST_DONE;
        else state_d = ST_ITER;
      end
      ST_ITER:  if (last_bit) state_d = ST_UPD;
      ST_UPD:   state_d = ST_CHECK;
      ST_DONE:  if (!out_valid_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eps_q       <= EPS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) eps_q <= cfg_data_i;
      if (state_q == ST_DONE && !out_valid_q) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        xneg_q <= in_i.point[POINT_W-1];
        tneg_q <= in_i.point[POINT_W-1];
        xmag_q <= pt_mag;
        tmag_q <= pt_mag;
        sum_q  <= '0;
        n_q    <= '0;
        hit_q  <= 1'b0;
      end
      ST_CHECK: begin
        if (!(tmag_q < MAG_W'(eps_q))) begin
          if (n_q >= NW'(MAX_TERMS)) begin
            hit_q <= 1'b1;
          end else begin
            n_q   <= n_q + 1'b1;
            div_q <= tmag_q;
            rem_q <= '0;
            mhi_q <= '0;
            mlo_q <= xmag_q;
            bit_q <= '0;
          end
        end
      end
      ST_ITER: begin
        rem_q <= qbit ? trial_sub[NW-1:0] : trial[NW-1:0];
        div_q <= {div_q[MAG_W-2:0], qbit};
        {mhi_q, mlo_q} <= {madd, mlo_q} >> 1;
        bit_q <= bit_q + 1'b1;
      end
      ST_UPD: begin
        sum_q  <= LOG_W'(sum_new);
        tmag_q <= prod[FRAC_BITS +: MAG_W];
        tneg_q <= (tneg_q == xneg_q);
      end
      ST_DONE: begin
        if (!out_valid_q) begin
          out_log_q   <= sum_q;
          out_terms_q <= n_ext[TERMS_W-1:0];
          out_hit_q   <= hit_q;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.log_value  = out_log_q;
  assign out_o.terms_used = out_terms_q;
  assign out_o.hit_limit  = out_hit_q;

`ifndef SYNTHESIS
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && hit_q) |-> (n_q == NW'(MAX_TERMS)))
    else $error("cap flag without full term count");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (bit_q <= BCW'(MAG_W - 1)))
    else $error("bit counter past word width");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CHECK && !in_i.ready))
    else $error("accepted word did not start evaluation");

  a_divisor_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (n_q != '0))
    else $error("divide by zero term index");
`endif

endmodule
